@@ rtl/core/sdtq_pkg.sv @@
// Shared constants, codes and inter-module structs of the sorted deadline timer queue.
// No dependencies; every other file of the block imports this package.
package sdtq_pkg;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned TIMER_COUNT = 16;

	localparam int unsigned QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SIDX_W = $clog2(TIMER_COUNT);
	localparam int unsigned SCNT_W = $clog2(TIMER_COUNT + 1);

	localparam int unsigned FUNC_W = 3;
	localparam int unsigned ID_W   = 4;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned STAT_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC    = 3'd0,
		FN_FREE     = 3'd1,
		FN_ARM      = 3'd2,
		FN_DISARM   = 3'd3,
		FN_DISPATCH = 3'd4
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC   = 2'd0,
		K_ACK     = 2'd1,
		K_EXPIRED = 2'd2,
		K_NONE    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_QFULL   = 3'd1,
		ST_NOID    = 3'd2,
		ST_NOTARM  = 3'd3,
		ST_FSFULL  = 3'd4
	} status_t;

	typedef struct packed {
		logic              en;
		logic [QIDX_W-1:0] idx;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   tid;
	} qwr_t;

	typedef struct packed {
		logic            vld;
		kind_t           kind;
		logic [ID_W-1:0] rid;
		status_t         status;
		logic            last;
	} beat_t;

endpackage

@@ rtl/core/sdtq_if.sv @@
// Valid/ready channel interfaces for command and result beats.
// Depends on sdtq_pkg for field widths.
interface sdtq_in_if import sdtq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   timer_id;
	logic [TIME_W-1:0] delay_cycles;
	logic [TIME_W-1:0] now;

	modport source (output valid, func, timer_id, delay_cycles, now, input ready);
	modport sink   (input valid, func, timer_id, delay_cycles, now, output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   result_id;
	logic [STAT_W-1:0] status;
	logic              last;

	modport source (output valid, kind, result_id, status, last, input ready);
	modport sink   (input valid, kind, result_id, status, last, output ready);
endinterface

@@ rtl/core/sdtq_queue_ram.sv @@
// Sorted queue storage: deadline and timer id per entry, one write and one read port.
// Depends on sdtq_pkg.
module sdtq_queue_ram import sdtq_pkg::*; (
	input  logic              clk,
	input  qwr_t              wr,
	input  logic [QIDX_W-1:0] rd_idx,
	output logic [TIME_W-1:0] rd_deadline,
	output logic [ID_W-1:0]   rd_tid
);

	logic [TIME_W-1:0] dl_mem [QUEUE_DEPTH];
	logic [ID_W-1:0]   id_mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			dl_mem[wr.idx] <= wr.deadline;
			id_mem[wr.idx] <= wr.tid;
		end
	end

	assign rd_deadline = dl_mem[rd_idx];
	assign rd_tid      = id_mem[rd_idx];

endmodule

@@ rtl/core/sdtq_ctrl.sv @@
// Sequencer: id allocator, free stack, and scan/shift control of the sorted queue
// around one shared 64-bit compare. Depends on sdtq_pkg and sdtq_if.
module sdtq_ctrl import sdtq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sdtq_in_if.sink           cmd,
	input  logic              out_free,
	output beat_t             emit,
	output qwr_t              wr,
	output logic [QIDX_W-1:0] rd_idx,
	input  logic [TIME_W-1:0] rd_deadline,
	input  logic [ID_W-1:0]   rd_tid
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_INS, S_DSRCH, S_DSHIFT, S_XSCAN, S_XCOMP, S_RESP
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic [ID_W-1:0]   tid_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] when_q;
	logic [QCNT_W-1:0] idx_q;
	logic [QCNT_W-1:0] base_q;
	logic [QCNT_W-1:0] occ_q;
	logic [SCNT_W-1:0] fsc_q;
	logic [SCNT_W-1:0] nfid_q;
	logic              pend_q;
	logic [ID_W-1:0]   pend_id_q;
	kind_t             rsp_kind_q;
	logic [ID_W-1:0]   rsp_id_q;
	status_t           rsp_status_q;
	logic [ID_W-1:0]   stack_q [TIMER_COUNT];

	logic [QCNT_W-1:0] idx_m1, idx_p1, src;
	logic [SCNT_W-1:0] fsc_m1;
	logic [TIME_W-1:0] cmp_ref;
	logic              rd_le;
	logic              expired;

	assign idx_m1  = idx_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign src     = idx_q + base_q;
	assign fsc_m1  = fsc_q - 1'b1;
	assign cmp_ref = (state_q == S_INS) ? when_q : now_q;
	assign rd_le   = rd_deadline <= cmp_ref;
	assign expired = (idx_q < occ_q) && rd_le;

	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_INS:    rd_idx = idx_m1[QIDX_W-1:0];
			S_DSHIFT: rd_idx = idx_p1[QIDX_W-1:0];
			S_XCOMP:  rd_idx = src[QIDX_W-1:0];
			default:  rd_idx = idx_q[QIDX_W-1:0];
		endcase
	end

	always_comb begin
		wr = '{en: 1'b0, idx: idx_q[QIDX_W-1:0], deadline: rd_deadline, tid: rd_tid};
		unique case (state_q)
			S_INS: begin
				wr.en = 1'b1;
				if (idx_q == '0 || rd_le) begin
					wr.deadline = when_q;
					wr.tid      = tid_q;
				end
			end
			S_DSHIFT: wr.en = (idx_p1 < occ_q);
			S_XCOMP:  wr.en = (src < occ_q);
			default:  wr.en = 1'b0;
		endcase
	end

	always_comb begin
		emit = '{vld: 1'b0, kind: K_ACK, rid: '0, status: ST_OK, last: 1'b1};
		unique case (state_q)
			S_XSCAN: begin
				if (expired) begin
					emit = '{vld: out_free && pend_q, kind: K_EXPIRED, rid: pend_id_q,
						status: ST_OK, last: 1'b0};
				end else if (pend_q) begin
					emit = '{vld: out_free, kind: K_EXPIRED, rid: pend_id_q,
						status: ST_OK, last: 1'b1};
				end else begin
					emit = '{vld: out_free, kind: K_NONE, rid: '0, status: ST_OK, last: 1'b1};
				end
			end
			S_RESP: begin
				emit = '{vld: out_free, kind: rsp_kind_q, rid: rsp_id_q,
					status: rsp_status_q, last: 1'b1};
			end
			default: emit.vld = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && func_q == FN_FREE && fsc_q < SCNT_W'(TIMER_COUNT)) begin
			stack_q[fsc_q[SIDX_W-1:0]] <= tid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			fsc_q        <= '0;
			nfid_q       <= '0;
			pend_q       <= 1'b0;
			func_q       <= FN_ALLOC;
			tid_q        <= '0;
			now_q        <= '0;
			when_q       <= '0;
			idx_q        <= '0;
			base_q       <= '0;
			pend_id_q    <= '0;
			rsp_kind_q   <= K_ACK;
			rsp_id_q     <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						func_q  <= func_t'(cmd.func);
						tid_q   <= cmd.timer_id;
						now_q   <= cmd.now;
						when_q  <= cmd.now + cmd.delay_cycles;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rsp_kind_q   <= K_ACK;
					rsp_id_q     <= '0;
					rsp_status_q <= ST_OK;
					idx_q        <= '0;
					pend_q       <= 1'b0;
					state_q      <= S_RESP;
					unique case (func_q)
						FN_ALLOC: begin
							rsp_kind_q <= K_ALLOC;
							if (fsc_q != '0) begin
								fsc_q    <= fsc_m1;
								rsp_id_q <= stack_q[fsc_m1[SIDX_W-1:0]];
							end else if (nfid_q < SCNT_W'(TIMER_COUNT)) begin
								rsp_id_q <= ID_W'(nfid_q);
								nfid_q   <= nfid_q + 1'b1;
							end else begin
								rsp_status_q <= ST_NOID;
							end
						end
						FN_FREE: begin
							if (fsc_q < SCNT_W'(TIMER_COUNT)) begin
								fsc_q <= fsc_q + 1'b1;
							end else begin
								rsp_status_q <= ST_FSFULL;
							end
						end
						FN_ARM: begin
							if (occ_q == QCNT_W'(QUEUE_DEPTH)) begin
								rsp_status_q <= ST_QFULL;
							end else begin
								idx_q   <= occ_q;
								state_q <= S_INS;
							end
						end
						FN_DISARM:   state_q <= S_DSRCH;
						FN_DISPATCH: state_q <= S_XSCAN;
						default:     state_q <= S_RESP;
					endcase
				end
				S_INS: begin
					if (idx_q != '0 && !rd_le) begin
						idx_q <= idx_m1;
					end else begin
						occ_q   <= occ_q + 1'b1;
						state_q <= S_RESP;
					end
				end
				S_DSRCH: begin
					if (idx_q >= occ_q) begin
						rsp_status_q <= ST_NOTARM;
						state_q      <= S_RESP;
					end else if (rd_tid == tid_q) begin
						state_q <= S_DSHIFT;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_DSHIFT: begin
					if (idx_p1 < occ_q) begin
						idx_q <= idx_p1;
					end else begin
						occ_q   <= occ_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_XSCAN: begin
					if (expired) begin
						if (!pend_q || out_free) begin
							pend_q    <= 1'b1;
							pend_id_q <= rd_tid;
							idx_q     <= idx_p1;
						end
					end else if (out_free) begin
						pend_q <= 1'b0;
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							base_q  <= idx_q;
							idx_q   <= '0;
							state_q <= S_XCOMP;
						end
					end
				end
				S_XCOMP: begin
					if (src < occ_q) begin
						idx_q <= idx_p1;
					end else begin
						occ_q   <= occ_q - base_q;
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/sorted_deadline_timer_queue_unit.sv @@
// Timer queue top level: alloc, free and unknown codes answer without walking the queue; arm,
// disarm and dispatch walk the sorted queue, and a dispatch with expired timers also compacts
// it. Every result beat is registered and can be held off by the result side.
// One command in flight; the next is taken only once the sequencer is back in idle, after
// its queue walk (disarm search and shift, or dispatch scan plus compaction) is done.
// Reset clears counters and sequencer; stores are never cleared. Depends on sdtq_pkg, sdtq_if.
module sorted_deadline_timer_queue_unit import sdtq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sdtq_in_if.sink   cmd,
	sdtq_out_if.source res
);

	qwr_t              wr;
	logic [QIDX_W-1:0] rd_idx;
	logic [TIME_W-1:0] rd_deadline;
	logic [ID_W-1:0]   rd_tid;
	beat_t             emit;
	beat_t             out_q;
	logic              out_vld_q;
	logic              out_free;

	assign out_free = !out_vld_q || res.ready;

	sdtq_queue_ram u_ram (
		.clk         (clk),
		.wr          (wr),
		.rd_idx      (rd_idx),
		.rd_deadline (rd_deadline),
		.rd_tid      (rd_tid)
	);

	sdtq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.out_free    (out_free),
		.emit        (emit),
		.wr          (wr),
		.rd_idx      (rd_idx),
		.rd_deadline (rd_deadline),
		.rd_tid      (rd_tid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit.vld) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.vld) begin
			out_q <= emit;
		end
	end

	assign res.valid     = out_vld_q;
	assign res.kind      = out_q.kind;
	assign res.result_id = out_q.rid;
	assign res.status    = out_q.status;
	assign res.last      = out_q.last;

endmodule

@@ rtl/core/sdtq_checker.sv @@
// Port-level checks of the timer queue, bound onto the top level.
// Depends on sdtq_pkg and sorted_deadline_timer_queue_unit.
module sdtq_checker import sdtq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [KIND_W-1:0] res_kind,
	input logic [ID_W-1:0]   res_id,
	input logic              res_last
);

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one still in work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped under backpressure");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != K_EXPIRED |-> res_last)
		else $error("single-beat result without last");

	a_ack_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == K_ACK || res_kind == K_NONE) |-> res_id == '0)
		else $error("non-zero id on acknowledge");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_id    (res.result_id),
	.res_last  (res.last)
);
